// ===== rtl/dti_pkg.sv =====
// ----------------------------------------------------------------------------
// dti_pkg
// Shared types, codes and constants of the diffusion table interpolator.
// ----------------------------------------------------------------------------
package dti_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = 7;
  localparam int unsigned TempW      = 24;
  localparam int unsigned ValW       = 24;
  localparam int unsigned EntryW     = TempW + ValW;

  // hbarc * 0.001 / (2 pi) in unsigned Q0.32 GeV fm
  localparam logic [27:0] ScaleQ32 = 28'd134885865;

  localparam logic [CountW-1:0] CountReset = 7'd2;
  localparam logic [CountW-1:0] CountMin   = 7'd2;
  localparam logic [CountW-1:0] CountMax   = 7'd64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] ST_WRITTEN  = 3'd0;
  localparam logic [2:0] ST_INTERP   = 3'd1;
  localparam logic [2:0] ST_BELOW    = 3'd2;
  localparam logic [2:0] ST_ABOVE    = 3'd3;
  localparam logic [2:0] ST_SATURATE = 3'd4;
  localparam logic [2:0] ST_ZERO_T   = 3'd5;

  typedef struct packed {
    logic                    operation;
    logic [AddrW-1:0]        entry_index;
    logic [TempW-1:0]        temperature;
    logic signed [ValW-1:0]  entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] diffusion;
    logic [2:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_SEARCH,
    S_RD_B,
    S_RD_A,
    S_MUL1,
    S_MUL2,
    S_DIV1_INIT,
    S_DIV1,
    S_DIV1_DONE,
    S_CHECK,
    S_SCALE,
    S_DIV2_INIT,
    S_DIV2,
    S_FINAL
  } state_e;

endpackage

// ===== rtl/dti_ram.sv =====
// ----------------------------------------------------------------------------
// dti_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dti_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/diffusion_table_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// diffusion_table_interpolator_unit
// Table lookup with linear interpolation/extrapolation, scaled to fm.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): a write item stores one
// table entry; a query item looks up a temperature. Output channel
// (out_valid_o / out_stall_i / out_item_o) returns one item per input item.
// Configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the
// number of table entries in use; write it only while the block is idle.
// The table sits in one RAM of 64 entries with a registered read port.
// One item is worked on at a time. Writes and zero-temperature queries need
// no table read. Other queries run a linear search over the table that reads
// one entry a cycle, then one shared multiplier forms the numerator in the
// states S_MUL1 and S_MUL2, a bit-serial divider takes 54 steps, the scale
// factor is applied by a 28-step shift-add, and a second divider takes 32
// steps. A flat table pair skips the numerator and first divider; a saturated
// result skips scaling and the second divider.
// A finished item waits in a holding register until the output register is
// free; the next item is accepted the cycle after it has moved on, so one item
// can sit stalled at the output while the next is worked on. Reset empties the
// output register, returns to idle and sets the entry count to 2; table
// contents are undefined until written.
// ----------------------------------------------------------------------------
module diffusion_table_interpolator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  dti_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output dti_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dti_pkg::CountW-1:0]         cfg_data_i
);

  dti_pkg::state_e state_q, state_d;

  logic [dti_pkg::CountW-1:0] entries_q;
  logic [dti_pkg::CountW-1:0] n_cl;

  logic                        ram_we;
  logic [dti_pkg::AddrW-1:0]   ram_raddr;
  logic [dti_pkg::EntryW-1:0]  ram_rdata;
  logic [dti_pkg::TempW-1:0]   rd_t;
  logic signed [dti_pkg::ValW-1:0] rd_v;

  logic [dti_pkg::TempW-1:0]   t_q;
  logic [dti_pkg::TempW-1:0]   t0_q, t1_q, tl_q;
  logic signed [dti_pkg::ValW-1:0] v0_q, v1_q, vl_q;
  logic [dti_pkg::AddrW-1:0]   a_q;
  logic [2:0]                  region_q;

  logic signed [51:0] prod_q;
  logic signed [52:0] num_q;
  logic               neg_q;
  logic [53:0]        vmag_q;
  logic               sat_q;
  logic [68:0]        acc_q;
  logic [67:0]        mcand_q;
  logic [68:0]        dvd_q;
  logic [35:0]        rem_q;
  logic [35:0]        div_q;
  logic [5:0]         cnt_q;

  logic                   out_valid_q;
  dti_pkg::out_item_t     out_item_q;
  logic signed [31:0]     res_diff_q;
  logic [2:0]             res_status_q;
  logic                   res_ready_q;

  logic accept;
  logic out_load;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                      t_zero;
  logic signed [24:0]        del;
  logic signed [25:0]        op_a, op_b, op_c, op_d;
  logic signed [25:0]        mul_x, mul_y;
  logic signed [51:0]        mul_p;
  logic signed [25:0]        t_s, t0_s, t1_s, v0_s, v1_s;
  logic signed [dti_pkg::ValW-1:0] anchor_v;
  logic [dti_pkg::ValW:0]    anchor_mag;
  logic [52:0]               num_mag;
  logic [53:0]               div1_dvd;
  logic [36:0]               div_tmp;
  logic                      div_ge;
  logic [35:0]               div_rem_n;
  logic                      in_table;
  logic                      below;
  logic [dti_pkg::CountW-1:0] a_ext;
  logic [31:0]               rmag;
  logic signed [31:0]        fin_diff;
  logic [2:0]                fin_status;

  assign accept      = in_valid_i && !in_stall_o;
  // a write or zero query finishes in idle; hold it off while a result waits
  assign in_stall_o  = (state_q != dti_pkg::S_IDLE) || res_ready_q;
  assign cfg_ready_o = 1'b1;
  assign t_zero      = (in_item_i.temperature == '0);
  assign ram_we      = accept && (in_item_i.operation == dti_pkg::OP_WRITE);

  assign rd_t = ram_rdata[dti_pkg::EntryW-1:dti_pkg::ValW];
  assign rd_v = $signed(ram_rdata[dti_pkg::ValW-1:0]);

  always_comb begin
    if (entries_q < dti_pkg::CountMin) begin
      n_cl = dti_pkg::CountMin;
    end else if (entries_q > dti_pkg::CountMax) begin
      n_cl = dti_pkg::CountMax;
    end else begin
      n_cl = entries_q;
    end
  end

  assign a_ext    = {1'b0, a_q};
  assign in_table = (t_q >= t0_q) && (t_q <= rd_t);
  assign below    = (t_q < t0_q);

  assign t_s  = $signed({2'b00, t_q});
  assign t0_s = $signed({2'b00, t0_q});
  assign t1_s = $signed({2'b00, t1_q});
  assign v0_s = {{2{v0_q[dti_pkg::ValW-1]}}, v0_q};
  assign v1_s = {{2{v1_q[dti_pkg::ValW-1]}}, v1_q};
  assign del  = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});

  always_comb begin
    case (region_q)
      dti_pkg::ST_BELOW: begin
        op_a     = v0_s;
        op_b     = {del[24], del};
        op_c     = t_s - t0_s;
        op_d     = v1_s - v0_s;
        anchor_v = v0_q;
      end
      dti_pkg::ST_ABOVE: begin
        op_a     = v1_s;
        op_b     = {del[24], del};
        op_c     = t_s - t1_s;
        op_d     = v1_s - v0_s;
        anchor_v = v1_q;
      end
      default: begin
        op_a     = v0_s;
        op_b     = t1_s - t_s;
        op_c     = v1_s;
        op_d     = t_s - t0_s;
        anchor_v = v0_q;
      end
    endcase
  end

  // one multiplier, shared by the S_MUL1 and S_MUL2 states
  assign mul_x = (state_q == dti_pkg::S_MUL2) ? op_c : op_a;
  assign mul_y = (state_q == dti_pkg::S_MUL2) ? op_d : op_b;
  assign mul_p = mul_x * mul_y;

  assign anchor_mag = anchor_v[dti_pkg::ValW-1] ?
                      -{anchor_v[dti_pkg::ValW-1], anchor_v} : {1'b0, anchor_v};

  assign num_mag  = num_q[52] ? 53'(-num_q) : 53'(num_q);
  assign div1_dvd = {1'b0, num_mag} + 54'({1'b0, del[23:1]});

  // one restoring division step
  assign div_tmp   = {rem_q, dvd_q[68]};
  assign div_ge    = (div_tmp >= {1'b0, div_q});
  assign div_rem_n = div_ge ? 36'(div_tmp - {1'b0, div_q}) : div_tmp[35:0];

  always_comb begin
    rmag       = dvd_q[31:0];
    fin_status = region_q;
    if (neg_q) begin
      if (sat_q || (rmag > 32'h8000_0000)) begin
        fin_diff   = 32'sh8000_0000;
        fin_status = dti_pkg::ST_SATURATE;
      end else begin
        fin_diff = $signed(32'(-rmag));
      end
    end else begin
      if (sat_q || (rmag > 32'h7FFF_FFFF)) begin
        fin_diff   = 32'sh7FFF_FFFF;
        fin_status = dti_pkg::ST_SATURATE;
      end else begin
        fin_diff = $signed(rmag);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next state and RAM read address
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    ram_raddr = '0;
    case (state_q)
      dti_pkg::S_IDLE: begin
        if (accept && (in_item_i.operation == dti_pkg::OP_QUERY) && !t_zero) begin
          state_d = dti_pkg::S_RD_FIRST;
        end
      end
      dti_pkg::S_RD_FIRST: begin
        ram_raddr = dti_pkg::AddrW'(n_cl - 7'd1);
        state_d   = dti_pkg::S_RD_LAST;
      end
      dti_pkg::S_RD_LAST: begin
        if (in_table) begin
          if (n_cl == 7'd2) begin
            state_d = dti_pkg::S_MUL1;
          end else begin
            ram_raddr = dti_pkg::AddrW'(1);
            state_d   = dti_pkg::S_SEARCH;
          end
        end else if (below) begin
          ram_raddr = dti_pkg::AddrW'(1);
          state_d   = dti_pkg::S_RD_B;
        end else begin
          ram_raddr = dti_pkg::AddrW'(n_cl - 7'd2);
          state_d   = dti_pkg::S_RD_A;
        end
      end
      dti_pkg::S_SEARCH: begin
        if (t_q > rd_t) begin
          if ((a_ext + 7'd3) < n_cl) begin
            ram_raddr = dti_pkg::AddrW'(a_ext + 7'd2);
          end else begin
            state_d = dti_pkg::S_MUL1;
          end
        end else begin
          state_d = dti_pkg::S_MUL1;
        end
      end
      dti_pkg::S_RD_B,
      dti_pkg::S_RD_A: begin
        state_d = dti_pkg::S_MUL1;
      end
      dti_pkg::S_MUL1: begin
        state_d = (del <= 25'sd0) ? dti_pkg::S_CHECK : dti_pkg::S_MUL2;
      end
      dti_pkg::S_MUL2: begin
        state_d = dti_pkg::S_DIV1_INIT;
      end
      dti_pkg::S_DIV1_INIT: begin
        state_d = dti_pkg::S_DIV1;
      end
      dti_pkg::S_DIV1: begin
        if (cnt_q == 6'd1) begin
          state_d = dti_pkg::S_DIV1_DONE;
        end
      end
      dti_pkg::S_DIV1_DONE: begin
        state_d = dti_pkg::S_CHECK;
      end
      dti_pkg::S_CHECK: begin
        state_d = (vmag_q >= {14'b0, t_q, 16'b0}) ? dti_pkg::S_FINAL : dti_pkg::S_SCALE;
      end
      dti_pkg::S_SCALE: begin
        if (cnt_q == 6'd27) begin
          state_d = dti_pkg::S_DIV2_INIT;
        end
      end
      dti_pkg::S_DIV2_INIT: begin
        state_d = dti_pkg::S_DIV2;
      end
      dti_pkg::S_DIV2: begin
        if (cnt_q == 6'd1) begin
          state_d = dti_pkg::S_FINAL;
        end
      end
      dti_pkg::S_FINAL: begin
        state_d = dti_pkg::S_IDLE;
      end
      default: begin
        state_d = dti_pkg::S_IDLE;
      end
    endcase
  end

  // a finished item moves to the output register when that is free
  assign out_load = res_ready_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dti_pkg::S_IDLE;
      entries_q   <= dti_pkg::CountReset;
      out_valid_q <= 1'b0;
      res_ready_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        entries_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        res_ready_q <= 1'b0;
      end else if ((accept && ((in_item_i.operation == dti_pkg::OP_WRITE) || t_zero)) ||
                   (state_q == dti_pkg::S_FINAL)) begin
        res_ready_q <= 1'b1;
      end
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q.diffusion <= res_diff_q;
      out_item_q.status    <= res_status_q;
    end
    case (state_q)
      dti_pkg::S_IDLE: begin
        if (accept) begin
          t_q          <= in_item_i.temperature;
          res_diff_q   <= '0;
          res_status_q <= (in_item_i.operation == dti_pkg::OP_WRITE) ?
                          dti_pkg::ST_WRITTEN : dti_pkg::ST_ZERO_T;
        end
      end
      dti_pkg::S_RD_FIRST: begin
        // address 0 was presented during idle
      end
      dti_pkg::S_RD_LAST: begin
        tl_q <= rd_t;
        vl_q <= rd_v;
        a_q  <= '0;
        if (in_table) begin
          region_q <= dti_pkg::ST_INTERP;
          t1_q     <= rd_t;
          v1_q     <= rd_v;
        end else if (below) begin
          region_q <= dti_pkg::ST_BELOW;
        end else begin
          region_q <= dti_pkg::ST_ABOVE;
        end
      end
      dti_pkg::S_SEARCH: begin
        if (t_q > rd_t) begin
          t0_q <= rd_t;
          v0_q <= rd_v;
          a_q  <= a_q + 1'b1;
          t1_q <= tl_q;
          v1_q <= vl_q;
        end else begin
          t1_q <= rd_t;
          v1_q <= rd_v;
        end
      end
      dti_pkg::S_RD_B: begin
        t1_q <= rd_t;
        v1_q <= rd_v;
      end
      dti_pkg::S_RD_A: begin
        t0_q <= rd_t;
        v0_q <= rd_v;
        t1_q <= tl_q;
        v1_q <= vl_q;
      end
      dti_pkg::S_MUL1: begin
        prod_q <= mul_p;
        neg_q  <= anchor_v[dti_pkg::ValW-1];
        vmag_q <= {29'b0, anchor_mag};
      end
      dti_pkg::S_MUL2: begin
        num_q <= {prod_q[51], prod_q} + {mul_p[51], mul_p};
      end
      dti_pkg::S_DIV1_INIT: begin
        neg_q <= num_q[52];
        dvd_q <= {div1_dvd, 15'b0};
        rem_q <= '0;
        div_q <= {12'b0, del[23:0]};
        cnt_q <= 6'd54;
      end
      dti_pkg::S_DIV1,
      dti_pkg::S_DIV2: begin
        rem_q <= div_rem_n;
        dvd_q <= {dvd_q[67:0], div_ge};
        cnt_q <= cnt_q - 6'd1;
      end
      dti_pkg::S_DIV1_DONE: begin
        vmag_q <= dvd_q[53:0];
      end
      dti_pkg::S_CHECK: begin
        sat_q   <= (vmag_q >= {14'b0, t_q, 16'b0});
        acc_q   <= {34'b0, t_q, 11'b0};
        mcand_q <= {28'b0, vmag_q[39:0]};
        cnt_q   <= '0;
      end
      dti_pkg::S_SCALE: begin
        if (dti_pkg::ScaleQ32[cnt_q[4:0]]) begin
          acc_q <= acc_q + {1'b0, mcand_q};
        end
        mcand_q <= {mcand_q[66:0], 1'b0};
        cnt_q   <= cnt_q + 6'd1;
      end
      dti_pkg::S_DIV2_INIT: begin
        rem_q <= acc_q[67:32];
        dvd_q <= {acc_q[31:0], 37'b0};
        div_q <= {t_q, 12'b0};
        cnt_q <= 6'd32;
      end
      dti_pkg::S_FINAL: begin
        res_diff_q   <= fin_diff;
        res_status_q <= fin_status;
      end
      default: begin
      end
    endcase
    if (state_q == dti_pkg::S_RD_FIRST) begin
      t0_q <= rd_t;
      v0_q <= rd_v;
    end
  end

  dti_ram #(
    .Width (dti_pkg::EntryW),
    .Depth (dti_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_item_i.entry_index),
    .wdata_i ({in_item_i.temperature, in_item_i.entry_value}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == dti_pkg::S_DIV1) || (state_q == dti_pkg::S_DIV2)) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_written_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_item_o.status == dti_pkg::ST_WRITTEN) ||
                     (out_item_o.status == dti_pkg::ST_ZERO_T)))
    |-> (out_item_o.diffusion == 32'sd0))
    else $error("write or zero-temperature item with non-zero result");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == dti_pkg::ST_SATURATE))
    |-> ((out_item_o.diffusion == 32'sh7FFF_FFFF) ||
         (out_item_o.diffusion == 32'sh8000_0000)))
    else $error("saturated item not at a limit");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_ready_q && !out_load) |=> res_ready_q)
    else $error("finished item lost before output load");

endmodule

// ===== verif/diffusion_table_interpolator_unit_test.sv =====
// ----------------------------------------------------------------------------
// diffusion_table_interpolator_unit_test
// Self-checking bench: writes tables, queries inside/below/above them, and
// compares every output item with a built-in fixed-point lookup predictor.
// ----------------------------------------------------------------------------
module diffusion_table_interpolator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [dti_pkg::CountW-1:0] cfg_data;
  dti_pkg::in_item_t in_item;
  dti_pkg::out_item_t out_item;

  diffusion_table_interpolator_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [dti_pkg::TempW-1:0] tab_temp [dti_pkg::TableDepth];
  logic signed [dti_pkg::ValW-1:0] tab_val [dti_pkg::TableDepth];
  int unsigned entry_count;

  dti_pkg::in_item_t pending_items[$];
  dti_pkg::out_item_t expected_lookups[$];
  int unsigned n_errors, n_queries, n_writes, n_sat, n_configs;
  longint unsigned cyc;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  task automatic queue_item(input dti_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endtask

  function automatic logic [63:0] mag(input longint signed x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic dti_pkg::out_item_t predict_lookup(input dti_pkg::in_item_t it);
    dti_pkg::out_item_t o;
    int unsigned n, lo, hi, anch;
    longint signed t, t0, t1, v0, v1, del, num;
    logic [2:0] st;
    logic neg;
    logic [63:0] vm, d, q, r, rm;
    o = '0;
    t = longint'(it.temperature);
    if (it.operation == dti_pkg::OP_WRITE) begin
      tab_temp[it.entry_index] = it.temperature;
      tab_val[it.entry_index] = it.entry_value;
      o.status = dti_pkg::ST_WRITTEN;
      return o;
    end
    if (t == 0) begin
      o.status = dti_pkg::ST_ZERO_T;
      return o;
    end
    n = entry_count < 2 ? 2 :
        (entry_count > dti_pkg::TableDepth ? dti_pkg::TableDepth : entry_count);
    if (t >= longint'(tab_temp[0]) && t <= longint'(tab_temp[n-1])) begin
      lo = 0;
      while (lo + 2 < n && t > longint'(tab_temp[lo+1])) lo++;
      hi = lo + 1; st = dti_pkg::ST_INTERP; anch = lo;
    end else if (t < longint'(tab_temp[0])) begin
      lo = 0; hi = 1; st = dti_pkg::ST_BELOW; anch = 0;
    end else begin
      lo = n - 2; hi = n - 1; st = dti_pkg::ST_ABOVE; anch = n - 1;
    end
    t0 = longint'(tab_temp[lo]); t1 = longint'(tab_temp[hi]);
    v0 = longint'(tab_val[lo]); v1 = longint'(tab_val[hi]);
    del = t1 - t0;
    if (del <= 0) begin
      num = longint'(tab_val[anch]);
      neg = num < 0; vm = mag(num);
    end else begin
      if (st == dti_pkg::ST_INTERP) num = v0 * (t1 - t) + v1 * (t - t0);
      else if (st == dti_pkg::ST_BELOW) num = v0 * del - (t0 - t) * (v1 - v0);
      else num = v1 * del + (t - t1) * (v1 - v0);
      neg = num < 0;
      vm = (mag(num) + 64'(del) / 2) / 64'(del);
    end
    d = 64'(t) * 4096;
    q = vm / d; r = vm % d;
    if (q >= 16) rm = 64'd2147483649;
    else rm = q * 64'(dti_pkg::ScaleQ32) + (r * 64'(dti_pkg::ScaleQ32) + d / 2) / d;
    if (neg) begin
      if (rm > 64'd2147483648) begin rm = 64'd2147483648; st = dti_pkg::ST_SATURATE; end
      o.diffusion = 32'(-rm);
    end else begin
      if (rm > 64'd2147483647) begin rm = 64'd2147483647; st = dti_pkg::ST_SATURATE; end
      o.diffusion = 32'(rm);
    end
    o.status = st;
    return o;
  endfunction

  function automatic dti_pkg::in_item_t mk(input logic op, input int unsigned idx,
                                           input int unsigned tp, input int vl);
    dti_pkg::in_item_t it;
    it.operation = op;
    it.entry_index = dti_pkg::AddrW'(idx);
    it.temperature = dti_pkg::TempW'(tp);
    it.entry_value = dti_pkg::ValW'(vl);
    return it;
  endfunction

  function automatic logic idle_now();
    // no idling in a long middle stretch of the run
    if (cyc > 40000 && cyc < 70000) return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_lookups = {expected_lookups, predict_lookup(in_item)};
        if (in_item.operation == dti_pkg::OP_QUERY) n_queries++; else n_writes++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && !idle_now()) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("output item with nothing expected");
        end else begin
          dti_pkg::out_item_t e;
          e = expected_lookups.pop_front();
          if (e.status == dti_pkg::ST_SATURATE) n_sat++;
          if (out_item.diffusion !== e.diffusion)
            report_mismatch($sformatf("diffusion %0d, predicted %0d",
                                      out_item.diffusion, e.diffusion));
          if (out_item.status !== e.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_item.status, e.status));
        end
      end
      out_stall <= idle_now();
    end
  end

  task automatic settle();
    while (pending_items.size() > 0 || in_valid || expected_lookups.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_count(input int unsigned n);
    cfg_valid <= 1'b1;
    cfg_data <= dti_pkg::CountW'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    entry_count = n;
    n_configs++;
  endtask

  // writes a full ascending table (all 64 slots filled so no unwritten entry
  // is read whatever the count)
  task automatic load_table(input logic wide);
    int unsigned step, tp;
    step = wide ? (24'hFFFFFF - 200) / 64 : $urandom_range(4000, 20);
    tp = $urandom_range(wide ? 50 : 300000, 1);
    for (int i = 0; i < dti_pkg::TableDepth; i++) begin
      queue_item(mk(dti_pkg::OP_WRITE, i, tp,
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(800000)));
      tp += $urandom_range(step, 1);
      if (tp > 24'hFFFFFF) tp = 24'hFFFFFF;
    end
  endtask

  function automatic int unsigned query_temp();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return $urandom_range(255);
    if (k == 1) return $urandom & 24'hFFFFFF;
    k = $urandom_range(entry_count - 1);
    return (int'(tab_temp[k]) + $urandom_range(4000) - 2000) & 24'hFFFFFF;
  endfunction

  initial begin
    int unsigned counts[6];
    counts = '{2, 64, 3, 17, 40, 64};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    entry_count = dti_pkg::CountReset;
    for (int i = 0; i < dti_pkg::TableDepth; i++) begin
      tab_temp[i] = '0;
      tab_val[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both regions, zero temperature, flat pairs
    queue_item(mk(dti_pkg::OP_WRITE, 0, 24'h000100, 24'h7FFFFF));
    queue_item(mk(dti_pkg::OP_WRITE, 1, 24'hFFFFFF, -8388608));
    queue_item(mk(dti_pkg::OP_QUERY, 63, 24'h000001, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h000080, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h800000, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'hFFFFFF, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 0, 24'hFFFFFF));
    queue_item(mk(dti_pkg::OP_WRITE, 1, 24'h000100, 24'h000010));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h000100, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h000050, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h100000, 0));
    queue_item(mk(dti_pkg::OP_WRITE, 0, 24'h100000, 24'h000100));
    queue_item(mk(dti_pkg::OP_WRITE, 1, 24'h200000, -24'h000100));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h180000, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'h000001, 0));
    queue_item(mk(dti_pkg::OP_QUERY, 0, 24'hFFFFFF, 0));
    settle();

    // random phases over several entry counts, one table reload mid-phase
    for (int ph = 0; ph < 6; ph++) begin
      set_count(counts[ph]);
      load_table(ph == 1);
      settle();
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(19) == 0)
          queue_item(mk(dti_pkg::OP_WRITE, $urandom_range(63), $urandom, $urandom));
        else
          queue_item(mk(dti_pkg::OP_QUERY, $urandom_range(63), query_temp(),
                        $urandom));
        if (k == 60) begin
          settle();
          load_table($urandom_range(1) == 1);
        end
      end
      settle();
    end
    set_count(2);
    for (int k = 0; k < 60; k++)
      queue_item(mk(dti_pkg::OP_QUERY, 0, query_temp(), 0));
    settle();

    $display("covered %0d queries, %0d table writes, %0d saturated, %0d counts",
             n_queries, n_writes, n_sat, n_configs);
    if (n_errors == 0 && expected_lookups.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== diffusion_table_interpolator_unit.f =====
rtl/dti_pkg.sv
rtl/dti_ram.sv
rtl/diffusion_table_interpolator_unit.sv
verif/diffusion_table_interpolator_unit_test.sv
